/* hdl/tvg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvg_pkg: shared types and constants of the torus vertex generator
// Divider step word, trig widths and pipeline depths.
// ----------------------------------------------------------------------------
package tvg_pkg;

	localparam int REM_W     = 26;  // partial remainder of the phase division
	localparam int DEN_W     = 10;  // divisor, twice the grid count
	localparam int QUO_W     = 17;  // quotient, one turn is 2^16
	localparam int DIV_STEPS = QUO_W;
	localparam int ANG_W     = 15;  // quarter-turn argument, 0..16384
	localparam int SIN_W     = 15;  // quarter sine magnitude, 0..16384
	localparam int SINE_LAT  = 6;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [QUO_W-1:0] quo;
	} div_t;

endpackage

/* hdl/torus_vertex_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// torus_vertex_generator: torus grid point to vertex, normal and quad indices
// Fully pipelined: phase dividers as a chain of step cells, then sine units
// and the position and normal products.
// ----------------------------------------------------------------------------
//
//  channel   signals                                   beat taken when
//  --------  ----------------------------------------  -----------------------
//  command   start, busy, slice_index, cap_index       start && !busy
//  result    done, pos_*, normal_*, corner_*, error    done (one cycle)
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
//  One command beat per clock. The setup register loads on the command edge;
//  after it come the 17 division cells, a phase stage, the six-stage sine
//  units, a trig stage, two product stages and the output register, which
//  puts each result on the ports. busy stays low: nothing in the pipe stalls.
//  Reset clears the valid line and loads the register defaults. The receiver
//  cannot hold results off, so done is a single-cycle strobe.
//
module torus_vertex_generator import tvg_pkg::*; #(
	parameter int MAX_SLICES = 256,
	parameter int MAX_CAPS   = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [7:0]         slice_index,
	input  logic [7:0]         cap_index,
	output logic               done,
	output logic signed [17:0] pos_x,
	output logic signed [17:0] pos_y,
	output logic signed [17:0] pos_z,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic [15:0]        corner_a,
	output logic [15:0]        corner_b,
	output logic [15:0]        corner_c,
	output logic [15:0]        corner_d,
	output logic               index_error,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam logic [2:0] REG_ORIENT = 3'd0;
	localparam logic [2:0] REG_SLICES = 3'd1;
	localparam logic [2:0] REG_CAPS   = 3'd2;
	localparam logic [2:0] REG_OUTER  = 3'd3;
	localparam logic [2:0] REG_TUBE   = 3'd4;

	localparam logic [1:0] ORIENT_YZ = 2'd1;
	localparam logic [1:0] ORIENT_ZX = 2'd2;

	localparam logic [12:0] MS = 13'(MAX_SLICES);
	localparam logic [12:0] MC = 13'(MAX_CAPS);

	// stages from the setup register to the product register
	localparam int SB_LEN = DIV_STEPS + SINE_LAT + 4;
	localparam int LAT    = SB_LEN + 2;

	localparam logic signed [49:0] PMAX = 50'sd131071;
	localparam logic signed [49:0] PMIN = -50'sd131072;

	typedef struct packed {
		logic        err;
		logic [15:0] ca;
		logic [15:0] cb;
		logic [15:0] cc;
		logic [15:0] cd;
	} side_t;

	typedef struct packed {
		logic [1:0] qs;
		logic [1:0] qc;
	} quad_t;

	function automatic logic signed [49:0] rnd(input logic signed [49:0] v, input int n);
		logic [49:0] mag;
		logic [49:0] r;
		mag = v[49] ? 50'(-v) : 50'(v);
		r   = (mag + (50'(1) << (n - 1))) >> n;
		return v[49] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [17:0] sat(input logic signed [49:0] v);
		if (v > PMAX) return 18'sd131071;
		if (v < PMIN) return -18'sd131072;
		return 18'(v);
	endfunction

	// configuration registers
	logic [1:0]  orient_q;
	logic [8:0]  slices_q, caps_q;
	logic [15:0] outer_q, tube_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orient_q <= 2'd0;
			slices_q <= 9'd16;
			caps_q   <= 9'd8;
			outer_q  <= 16'd256;
			tube_q   <= 16'd64;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ORIENT: orient_q <= cfg_data[1:0];
				REG_SLICES: slices_q <= cfg_data[8:0];
				REG_CAPS:   caps_q   <= cfg_data[8:0];
				REG_OUTER:  outer_q  <= cfg_data;
				REG_TUBE:   tube_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// setup stage: effective counts, range check, wrap, corner indices
	logic        accept;
	logic [8:0]  ns, nc, nsl, ncp;
	logic [16:0] base_s, base_n;
	side_t       side_c, side_s1;
	div_t        dsl_s1, dcp_s1;
	logic        vld_s1;

	assign accept = start && !busy;

	always_comb begin
		ns     = ({4'b0, slices_q} > MS) ? MS[8:0] : slices_q;
		nc     = ({4'b0, caps_q} > MC) ? MC[8:0] : caps_q;
		nsl    = ({1'b0, slice_index} + 9'd1 == ns) ? 9'd0 : {1'b0, slice_index} + 9'd1;
		ncp    = ({1'b0, cap_index} + 9'd1 == nc) ? 9'd0 : {1'b0, cap_index} + 9'd1;
		base_s = 17'(slice_index) * 17'(nc);
		base_n = 17'(nsl) * 17'(nc);
		side_c.err = ({1'b0, slice_index} >= ns) || ({1'b0, cap_index} >= nc);
		side_c.ca  = 16'(base_n + 17'(cap_index));
		side_c.cb  = 16'(base_n + 17'(ncp));
		side_c.cc  = 16'(base_s + 17'(ncp));
		side_c.cd  = 16'(base_s + 17'(cap_index));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		side_s1    <= side_c;
		// phase = idx/count rounded half up, as (2^17 idx + n) / 2n
		dsl_s1.rem <= REM_W'({slice_index, 17'b0}) + REM_W'(ns);
		dsl_s1.den <= {ns, 1'b0};
		dsl_s1.quo <= '0;
		dcp_s1.rem <= REM_W'({cap_index, 17'b0}) + REM_W'(nc);
		dcp_s1.den <= {nc, 1'b0};
		dcp_s1.quo <= '0;
	end

	// division cell chains, quotient MSB first
	div_t sl_chain [DIV_STEPS+1];
	div_t cp_chain [DIV_STEPS+1];

	assign sl_chain[0] = dsl_s1;
	assign cp_chain[0] = dcp_s1;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		tvg_div_cell #(.BIT(DIV_STEPS - 1 - k)) u_sl (
			.clk (clk),
			.src (sl_chain[k]),
			.dst (sl_chain[k+1])
		);
		tvg_div_cell #(.BIT(DIV_STEPS - 1 - k)) u_cp (
			.clk (clk),
			.src (cp_chain[k]),
			.dst (cp_chain[k+1])
		);
	end

	// phase stage: quadrant and quarter-turn arguments
	logic [15:0]      ph_sl, ph_cp;
	logic [ANG_W-1:0] ts_a_s, ts_b_s, tc_a_s, tc_b_s;
	quad_t            quad_s;

	assign ph_sl = sl_chain[DIV_STEPS].quo[15:0];
	assign ph_cp = cp_chain[DIV_STEPS].quo[15:0];

	always_ff @(posedge clk) begin
		quad_s.qs <= ph_sl[15:14];
		quad_s.qc <= ph_cp[15:14];
		ts_a_s    <= {1'b0, ph_sl[13:0]};
		ts_b_s    <= ANG_W'(16384) - {1'b0, ph_sl[13:0]};
		tc_a_s    <= {1'b0, ph_cp[13:0]};
		tc_b_s    <= ANG_W'(16384) - {1'b0, ph_cp[13:0]};
	end

	logic [SIN_W-1:0] sa, sb, ca, cb;

	tvg_sine u_sin_sa (.clk(clk), .angle(ts_a_s), .sine(sa));
	tvg_sine u_sin_sb (.clk(clk), .angle(ts_b_s), .sine(sb));
	tvg_sine u_sin_ca (.clk(clk), .angle(tc_a_s), .sine(ca));
	tvg_sine u_sin_cb (.clk(clk), .angle(tc_b_s), .sine(cb));

	// hold the quadrants alongside the sine units
	quad_t quad_q [SINE_LAT];

	always_ff @(posedge clk) begin
		quad_q[0] <= quad_s;
		for (int i = 1; i < SINE_LAT; i++) quad_q[i] <= quad_q[i-1];
	end

	// trig stage: fold the quadrant back in
	logic signed [15:0] pa_s, pb_s, pa_c, pb_c;
	logic signed [15:0] ss_n, cs_n, sc_n, cc_n;
	logic signed [15:0] ss_s, cs_s, sc_s, cc_s;

	always_comb begin
		pa_s = $signed({1'b0, sa});
		pb_s = $signed({1'b0, sb});
		pa_c = $signed({1'b0, ca});
		pb_c = $signed({1'b0, cb});
		case (quad_q[SINE_LAT-1].qs)
			2'd0:    begin ss_n = pa_s;  cs_n = pb_s;  end
			2'd1:    begin ss_n = pb_s;  cs_n = -pa_s; end
			2'd2:    begin ss_n = -pa_s; cs_n = -pb_s; end
			default: begin ss_n = -pb_s; cs_n = pa_s;  end
		endcase
		case (quad_q[SINE_LAT-1].qc)
			2'd0:    begin sc_n = pa_c;  cc_n = pb_c;  end
			2'd1:    begin sc_n = pb_c;  cc_n = -pa_c; end
			2'd2:    begin sc_n = -pa_c; cc_n = -pb_c; end
			default: begin sc_n = -pb_c; cc_n = pa_c;  end
		endcase
	end

	always_ff @(posedge clk) begin
		ss_s <= ss_n;
		cs_s <= cs_n;
		sc_s <= sc_n;
		cc_s <= cc_n;
	end

	// first products: ring radius at this cap, tube height, normals
	logic signed [33:0] rad_s;
	logic signed [32:0] pw_s;
	logic signed [31:0] nu_s, nv_s;
	logic signed [15:0] ss_m, cs_m, sc_m;

	always_ff @(posedge clk) begin
		rad_s <= $signed({4'b0, outer_q, 14'b0}) + 34'(cc_s * $signed({1'b0, tube_q}));
		pw_s  <= sc_s * $signed({1'b0, tube_q});
		nu_s  <= cc_s * cs_s;
		nv_s  <= cc_s * ss_s;
		ss_m  <= ss_s;
		cs_m  <= cs_s;
		sc_m  <= sc_s;
	end

	// second products: ring position
	logic signed [49:0] pu_p, pv_p, pw_p, nu_p, nv_p;
	logic signed [15:0] nw_p;

	always_ff @(posedge clk) begin
		pu_p <= 50'(cs_m * rad_s);
		pv_p <= 50'(ss_m * rad_s);
		pw_p <= 50'(pw_s);
		nu_p <= 50'(nu_s);
		nv_p <= 50'(nv_s);
		nw_p <= sc_m;
	end

	// valid and side data ride along the pipe
	logic  vld_q [SB_LEN];
	side_t side_q [SB_LEN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SB_LEN; i++) vld_q[i] <= 1'b0;
		end else begin
			vld_q[0] <= vld_s1;
			for (int i = 1; i < SB_LEN; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		side_q[0] <= side_s1;
		for (int i = 1; i < SB_LEN; i++) side_q[i] <= side_q[i-1];
	end

	// output stage: round, saturate, permute axes, zero on error
	logic signed [17:0] pu_r, pv_r, pw_r;
	logic signed [15:0] nu_r, nv_r;
	side_t              side_o;

	always_comb begin
		side_o = side_q[SB_LEN-1];
		pu_r   = sat(rnd(pu_p, 28));
		pv_r   = sat(rnd(pv_p, 28));
		pw_r   = sat(rnd(pw_p, 14));
		nu_r   = 16'(rnd(nu_p, 14));
		nv_r   = 16'(rnd(nv_p, 14));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= vld_q[SB_LEN-1];
	end

	always_ff @(posedge clk) begin
		index_error <= side_o.err;
		if (side_o.err) begin
			pos_x <= '0; pos_y <= '0; pos_z <= '0;
			normal_x <= '0; normal_y <= '0; normal_z <= '0;
			corner_a <= '0; corner_b <= '0; corner_c <= '0; corner_d <= '0;
		end else begin
			corner_a <= side_o.ca;
			corner_b <= side_o.cb;
			corner_c <= side_o.cc;
			corner_d <= side_o.cd;
			if (orient_q == ORIENT_YZ) begin
				pos_x <= pw_r; pos_y <= pu_r; pos_z <= pv_r;
				normal_x <= nw_p; normal_y <= nu_r; normal_z <= nv_r;
			end else if (orient_q == ORIENT_ZX) begin
				pos_x <= pv_r; pos_y <= pw_r; pos_z <= pu_r;
				normal_x <= nv_r; normal_y <= nw_p; normal_z <= nu_r;
			end else begin
				pos_x <= pu_r; pos_y <= pv_r; pos_z <= pw_r;
				normal_x <= nu_r; normal_y <= nv_r; normal_z <= nw_p;
			end
		end
	end

`ifndef ASSERT_OFF
	// every command beat comes out as a done strobe at the end of the pipe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result strobe missing at pipeline depth");

	// no strobe without a matching command beat
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(start && !busy, LAT))
		else $error("result strobe without command");

	// an error result carries no geometry
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && index_error) |-> (pos_x == 0 && pos_y == 0 && pos_z == 0 &&
			normal_x == 0 && normal_y == 0 && normal_z == 0 && corner_d == 0))
		else $error("error result with nonzero fields");

	// normal_z stays within the unit sphere bounds
	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (normal_z <= 16'sd16384 && normal_z >= -16'sd16384))
		else $error("normal component out of range");
`endif

endmodule

/* hdl/tvg_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvg_div_cell: one restoring division step
// Settles quotient bit BIT and hands the word to the next cell.
// ----------------------------------------------------------------------------
module tvg_div_cell import tvg_pkg::*; #(
	parameter int BIT = 0
) (
	input  logic clk,
	input  div_t src,
	output div_t dst
);

	logic [REM_W-1:0] shifted;
	logic             take;
	div_t             nxt;

	always_comb begin
		shifted = REM_W'(src.den) << BIT;
		take    = (src.rem >= shifted);
		nxt     = src;
		if (take) begin
			nxt.rem      = src.rem - shifted;
			nxt.quo[BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		dst <= nxt;
	end

endmodule

/* hdl/tvg_sine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvg_sine: quarter-wave sine, pipelined Horner polynomial
// One multiply per stage, six stages, result in Q1.14.
// ----------------------------------------------------------------------------
module tvg_sine import tvg_pkg::*; (
	input  logic             clk,
	input  logic [ANG_W-1:0] angle,
	output logic [SIN_W-1:0] sine
);

	localparam logic [30:0] A1 = 31'd1686629713;
	localparam logic [30:0] A3 = 31'd693598668;
	localparam logic [30:0] A5 = 31'd85569306;
	localparam logic [30:0] A7 = 31'd5026995;
	localparam logic [30:0] A9 = 31'd172272;
	localparam logic [SIN_W-1:0] ONE = SIN_W'(16384);

	logic [ANG_W-1:0] t_s1, t_s2, t_s3, t_s4, t_s5;
	logic [ANG_W-1:0] t2_s1, t2_s2, t2_s3, t2_s4;
	logic [30:0]      p_s2, p_s3, p_s4, p_s5;
	logic [29:0]      sq;
	logic [45:0]      m2, m3, m4, m5, mf;
	logic [46:0]      fin;

	always_comb begin
		sq  = 30'(angle) * 30'(angle);
		m2  = 46'(t2_s1) * 46'(A9);
		m3  = 46'(t2_s2) * 46'(p_s2);
		m4  = 46'(t2_s3) * 46'(p_s3);
		m5  = 46'(t2_s4) * 46'(p_s4);
		mf  = 46'(t_s5) * 46'(p_s5);
		fin = (47'(mf) + (47'(1) << 29)) >> 30;
	end

	always_ff @(posedge clk) begin
		t_s1  <= angle;
		t2_s1 <= ANG_W'(sq >> 14);
		t_s2  <= t_s1;
		t2_s2 <= t2_s1;
		p_s2  <= A7 - 31'(m2 >> 14);
		t_s3  <= t_s2;
		t2_s3 <= t2_s2;
		p_s3  <= A5 - 31'(m3 >> 14);
		t_s4  <= t_s3;
		t2_s4 <= t2_s3;
		p_s4  <= A3 - 31'(m4 >> 14);
		t_s5  <= t_s4;
		p_s5  <= A1 - 31'(m5 >> 14);
		// cap at exactly one
		sine  <= (fin > 47'(ONE)) ? ONE : SIN_W'(fin);
	end

endmodule
